// ----- hdl/mse_pkg.sv -----
package mse_pkg;

    // Width of one element and default store capacity.
    localparam int DATA_W    = 32;
    localparam int DEPTH_DEF = 64;

    // Sequencer states of the sort engine.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_MERGE,
        S_OUT_RD,
        S_OUT_SHOW
    } t_state;

endpackage

// ----- hdl/mse_bank.sv -----
module mse_bank
    import mse_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr_a,
    input  logic [AW-1:0]     i_raddr_b,
    output logic [DATA_W-1:0] o_rdata_a,
    output logic [DATA_W-1:0] o_rdata_b
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata_a;
    logic [DATA_W-1:0] r_rdata_b;

    // One write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Two read ports with registered data.
    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- hdl/mse_cmp.sv -----
module mse_cmp
    import mse_pkg::*;
(
    input  logic              i_left_avail,
    input  logic              i_right_avail,
    input  logic [DATA_W-1:0] i_left,
    input  logic [DATA_W-1:0] i_right,
    output logic              o_take_left
);

    // The left run wins ties, and an exhausted run never wins.
    assign o_take_left = i_left_avail &&
                         (!i_right_avail || ($signed(i_left) <= $signed(i_right)));

endmodule

// ----- hdl/merge_sort_engine_unit.sv -----
// Loading accepts one item per cycle; the block is ready for items only while loading.
// After the last item, each merge pass writes every item once, after a set-up state per run pair,
// over ceil(log2 n) passes, then a priming read and one result per cycle when not stalled.
// The merge rate is set by the single compare unit and the two read ports of the source bank.
// Reset is synchronous and active low: it clears the sequencer, the count and the drop flag;
// the two element banks are not cleared.
module merge_sort_engine_unit
    import mse_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] value
    input  logic              s_axis_tlast,   // last
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] sorted_value
    output logic              m_axis_tlast,   // last_res
    output logic              m_axis_tuser    // [0] overflow
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 2;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_drop,  n_drop;
    logic [CW-1:0]   r_n,     n_n;
    logic [CW:0]     r_w,     n_w;
    logic [CW-1:0]   r_lo,    n_lo;
    logic [CW-1:0]   r_mid,   n_mid;
    logic [CW-1:0]   r_hi,    n_hi;
    logic [CW-1:0]   r_i,     n_i;
    logic [CW-1:0]   r_j,     n_j;
    logic [CW-1:0]   r_k,     n_k;
    logic            r_src,   n_src;
    logic [CW-1:0]   r_ok,    n_ok;

    logic [AW-1:0]     rd_a, rd_b, waddr;
    logic [DATA_W-1:0] wdata;
    logic              we0, we1;
    logic [DATA_W-1:0] b0_a, b0_b, b1_a, b1_b;
    logic [DATA_W-1:0] head_l, head_r;
    logic              take_left;
    logic              out_last;

    // Clamp a wide run bound to the batch size.
    function automatic logic [CW-1:0] clamp_n(input logic [SW-1:0] x, input logic [CW-1:0] n);
        return (x > {2'b00, n}) ? n : x[CW-1:0];
    endfunction

    // Ping-pong element banks: bank 0 is loaded, passes alternate between them.
    mse_bank #(.DEPTH(DEPTH), .AW(AW)) u_bank0 (
        .i_clk     (i_clk),
        .i_we      (we0),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (rd_a),
        .i_raddr_b (rd_b),
        .o_rdata_a (b0_a),
        .o_rdata_b (b0_b)
    );

    mse_bank #(.DEPTH(DEPTH), .AW(AW)) u_bank1 (
        .i_clk     (i_clk),
        .i_we      (we1),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (rd_a),
        .i_raddr_b (rd_b),
        .o_rdata_a (b1_a),
        .o_rdata_b (b1_b)
    );

    assign head_l = r_src ? b1_a : b0_a;
    assign head_r = r_src ? b1_b : b0_b;

    // Shared compare unit deciding which run head goes next.
    mse_cmp u_cmp (
        .i_left_avail  (r_i < r_mid),
        .i_right_avail (r_j < r_hi),
        .i_left        (head_l),
        .i_right       (head_r),
        .o_take_left   (take_left)
    );

    // Output port: data comes straight from the registered bank read.
    assign out_last      = ((r_ok + CW'(1)) == r_n);
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT_SHOW);
    assign m_axis_tdata  = head_l;
    assign m_axis_tlast  = out_last;
    assign m_axis_tuser  = r_drop;

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_drop  <= n_drop;
        end
    end

    // Run pointers need no reset: they are set before use.
    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_w   <= n_w;
        r_lo  <= n_lo;
        r_mid <= n_mid;
        r_hi  <= n_hi;
        r_i   <= n_i;
        r_j   <= n_j;
        r_k   <= n_k;
        r_src <= n_src;
        r_ok  <= n_ok;
    end

    // Sequencer: load, merge passes, then emit.
    always_comb begin
        logic [CW-1:0] nn;
        logic [SW-1:0] new_lo;
        logic [SW-1:0] w2;
        logic [CW-1:0] ni, nj, nmid;

        n_state = r_state;
        n_count = r_count;
        n_drop  = r_drop;
        n_n     = r_n;
        n_w     = r_w;
        n_lo    = r_lo;
        n_mid   = r_mid;
        n_hi    = r_hi;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_src   = r_src;
        n_ok    = r_ok;
        rd_a    = r_i[AW-1:0];
        rd_b    = r_j[AW-1:0];
        waddr   = r_k[AW-1:0];
        wdata   = take_left ? head_l : head_r;
        we0     = 1'b0;
        we1     = 1'b0;
        nn      = r_count;
        new_lo  = '0;
        w2      = '0;
        ni      = r_i;
        nj      = r_j;
        nmid    = r_mid;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    // Store the item, or drop it when the store is full.
                    if (r_count < CW'(DEPTH)) begin
                        we0     = 1'b1;
                        waddr   = r_count[AW-1:0];
                        wdata   = s_axis_tdata;
                        n_count = r_count + CW'(1);
                        nn      = r_count + CW'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_n   = nn;
                        n_src = 1'b0;
                        n_ok  = '0;
                        n_w   = (CW + 1)'(1);
                        n_lo  = '0;
                        n_mid = CW'(1);
                        n_hi  = CW'(2);
                        n_i   = '0;
                        n_j   = CW'(1);
                        n_k   = '0;
                        // A single item needs no merge pass.
                        n_state = (nn == CW'(1)) ? S_OUT_RD : S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                // Reads of both run heads are under way.
                n_state = S_MERGE;
            end
            S_MERGE: begin
                // Write the winner, advance its run and fetch its next head.
                if (r_src) begin
                    we0 = 1'b1;
                end else begin
                    we1 = 1'b1;
                end
                if (take_left) begin
                    ni = r_i + CW'(1);
                end else begin
                    nj = r_j + CW'(1);
                end
                n_i  = ni;
                n_j  = nj;
                n_k  = r_k + CW'(1);
                rd_a = ni[AW-1:0];
                rd_b = nj[AW-1:0];
                if ((r_k + CW'(1)) == r_hi) begin
                    new_lo = SW'(r_lo) + (SW'(r_w) << 1);
                    if (new_lo >= SW'(r_n)) begin
                        // Pass complete: the destination becomes the source.
                        w2    = SW'(r_w) << 1;
                        n_src = !r_src;
                        n_w   = w2[CW:0];
                        n_ok  = '0;
                        nmid  = clamp_n(w2, r_n);
                        n_lo  = '0;
                        n_mid = nmid;
                        n_hi  = clamp_n(w2 << 1, r_n);
                        n_i   = '0;
                        n_j   = nmid;
                        n_k   = '0;
                        n_state = (w2 >= SW'(r_n)) ? S_OUT_RD : S_SETUP;
                    end else begin
                        // Next pair of runs in this pass.
                        nmid  = clamp_n(new_lo + SW'(r_w), r_n);
                        n_lo  = new_lo[CW-1:0];
                        n_mid = nmid;
                        n_hi  = clamp_n(new_lo + (SW'(r_w) << 1), r_n);
                        n_i   = new_lo[CW-1:0];
                        n_j   = nmid;
                        n_k   = new_lo[CW-1:0];
                        n_state = S_SETUP;
                    end
                end
            end
            S_OUT_RD: begin
                rd_a    = r_ok[AW-1:0];
                n_state = S_OUT_SHOW;
            end
            S_OUT_SHOW: begin
                // Hold the address until the result is taken, then fetch the next.
                rd_a = r_ok[AW-1:0];
                if (m_axis_tready) begin
                    if (out_last) begin
                        n_count = '0;
                        n_drop  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_ok = r_ok + CW'(1);
                        rd_a = n_ok[AW-1:0];
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
